>>> rtl/core/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, widths and constants of the byte pattern search core.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int PATTERN_MAX = 128;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

    localparam int OP_W        = 2;
    localparam int SLOT_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 8;
    localparam int MAXM_W      = 16;

    localparam int CMP_W       = ((LEN_W > SLOT_W) ? LEN_W : SLOT_W) + 1;

    localparam int GROUP_W     = 8;
    localparam int NGROUPS     = (PATTERN_MAX + GROUP_W - 1) / GROUP_W;

    localparam int IN_TDATA_W  = ((SLOT_W + BYTE_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = MAXM_W;

    // queue depth must be a power of two: pointers wrap naturally
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_LOAD  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_START = OP_W'(1);
    localparam logic [OP_W-1:0] OP_DATA  = OP_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES    = CFG_IDX_W'(1);

    localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(1);
    localparam logic [MAXM_W-1:0] MAXM_RESET = MAXM_W'(20);

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_START,
        KIND_DATA
    } kind_t;

    typedef enum logic {
        BK_RUN,
        BK_SWEEP
    } back_state_t;

    typedef struct packed {
        kind_t               kind;
        logic                load_ok;
        logic [SLOT_W-1:0]   slot;
        logic [BYTE_W-1:0]   value;
        logic [ADDR_W-1:0]   addr;
    } cmd_t;

    // pattern length as used: zero acts as one, large values clip
    function automatic logic [LEN_W-1:0] eff_len(input logic [PLEN_W-1:0] v);
        int unsigned x;
        x = int'(v);
        if (x == 0)
        begin
            x = 1;
        end
        else if (x > PATTERN_MAX)
        begin
            x = PATTERN_MAX;
        end
        return LEN_W'(x);
    endfunction

endpackage

>>> rtl/core/bps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_front
// Input side: accepts items, decodes the operation and range-checks loads.
// ----------------------------------------------------------------------------
module bps_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [bps_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                            q_full,
    output logic                            push,
    output bps_pkg::cmd_t                   cmd
);
    import bps_pkg::*;

    logic known;

    always_comb
    begin
        cmd.slot  = s_axis_tdata[SLOT_W-1:0];
        cmd.value = s_axis_tdata[SLOT_W +: BYTE_W];
        cmd.addr  = s_axis_tdata[SLOT_W + BYTE_W +: ADDR_W];
        cmd.load_ok = CMP_W'(s_axis_tdata[SLOT_W-1:0]) < CMP_W'(PATTERN_MAX);
        known    = 1'b1;
        case (s_axis_tuser)
            OP_LOAD:  cmd.kind = KIND_LOAD;
            OP_START: cmd.kind = KIND_START;
            OP_DATA:  cmd.kind = KIND_DATA;
            default:
            begin
                // unused code: taken and dropped
                cmd.kind = KIND_DATA;
                known    = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full && known;

endmodule

>>> rtl/core/bps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_queue
// Short FIFO of decoded items between the input side and the search engine.
// ----------------------------------------------------------------------------
module bps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bps_pkg::cmd_t cmd_in,
    input  logic          pop,
    output bps_pkg::cmd_t cmd_out,
    output logic          empty,
    output logic          full
);
    import bps_pkg::*;

    cmd_t                 slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign empty   = (count_reg == Q_CNT_W'(0));
    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> rtl/core/bps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_back
// Search engine: pattern store, sliding window, grouped compare, match
// counting and output register. The pattern is held reversed against the
// window, so lane i compares window byte i with pattern byte len-1-i.
// ----------------------------------------------------------------------------
module bps_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            q_empty,
    input  bps_pkg::cmd_t                   q_cmd,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bps_pkg::*;

    logic [PLEN_W-1:0]   plen_reg;
    logic [MAXM_W-1:0]   maxm_reg;
    logic [LEN_W-1:0]    eff;
    logic [CMP_W-1:0]    eff_x;
    logic                len_wr;

    back_state_t         state_reg, state_next;
    logic                sweeping;
    logic [IDX_W-1:0]    sw_idx_reg;
    logic [IDX_W-1:0]    sw_last;
    logic [IDX_W-1:0]    sw_raddr;
    logic                sw_pend_reg;
    logic [IDX_W-1:0]    sw_pidx_reg;
    logic [BYTE_W-1:0]   ram_rdata;

    logic [BYTE_W-1:0]   pat_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]   win_reg [PATTERN_MAX-1];
    logic [LEN_W-1:0]    seen_reg;
    logic [LEN_W-1:0]    seen_inc;

    logic                en;
    logic                is_load, is_start, is_data;
    logic                ram_we;
    logic                load_hit;
    logic [IDX_W-1:0]    load_idx;
    logic [PATTERN_MAX-1:0] eq;
    logic [NGROUPS-1:0]  grp;

    logic                s1_valid_reg;
    kind_t               s1_kind_reg;
    logic                s1_elig_reg;
    logic [NGROUPS-1:0]  s1_grp_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;

    logic [MAXM_W-1:0]   cnt_reg;
    logic                hit, emit;
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;

    // ---------------------------------------------------------------- config
    assign len_wr = cfg_we && (cfg_index == CFG_PATTERN_LENGTH);
    assign eff    = eff_len(plen_reg);
    assign eff_x  = CMP_W'(eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= PLEN_RESET;
            maxm_reg <= MAXM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PATTERN_LENGTH)
            begin
                plen_reg <= cfg_data[PLEN_W-1:0];
            end
            else if (cfg_index == CFG_MAX_MATCHES)
            begin
                maxm_reg <= cfg_data[MAXM_W-1:0];
            end
        end
    end

    // ------------------------------------------- realignment after len write
    assign sw_last  = IDX_W'(eff_x - CMP_W'(1));
    assign sw_raddr = IDX_W'(eff_x - CMP_W'(1) - CMP_W'(sw_idx_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (len_wr)
                begin
                    state_next = BK_SWEEP;
                end
            end
            BK_SWEEP:
            begin
                if (!len_wr && sw_idx_reg == sw_last)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            BK_SWEEP: sweeping = 1'b1;
            default:  sweeping = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_RUN;
            sw_idx_reg  <= '0;
            sw_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sw_pend_reg <= sweeping;
            if (len_wr)
            begin
                sw_idx_reg <= '0;
            end
            else if (sweeping)
            begin
                sw_idx_reg <= sw_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sw_pidx_reg <= sw_idx_reg;
    end

    // ---------------------------------------------------------- issue stage
    assign en       = !out_valid_reg || m_axis_tready;
    assign pop      = en && !sweeping && !sw_pend_reg && !len_wr && !q_empty;
    assign is_load  = (q_cmd.kind == KIND_LOAD);
    assign is_start = (q_cmd.kind == KIND_START);
    assign is_data  = (q_cmd.kind == KIND_DATA);

    assign ram_we   = pop && is_load && q_cmd.load_ok;
    assign load_hit = ram_we && (CMP_W'(q_cmd.slot) < eff_x);
    assign load_idx = IDX_W'(eff_x - CMP_W'(1) - CMP_W'(q_cmd.slot));

    bps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(q_cmd.slot)),
        .wdata (q_cmd.value),
        .raddr (sw_raddr),
        .rdata (ram_rdata)
    );

    assign seen_inc = (seen_reg == LEN_W'(PATTERN_MAX)) ? seen_reg
                                                        : seen_reg + LEN_W'(1);

    always_comb
    begin
        eq[0] = (q_cmd.value == pat_reg[0]);
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            eq[i] = (win_reg[i-1] == pat_reg[i]) || (CMP_W'(i) >= eff_x);
        end
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp[g] = 1'b1;
            for (int j = 0; j < GROUP_W; j++)
            begin
                if (g * GROUP_W + j < PATTERN_MAX)
                begin
                    grp[g] = grp[g] & eq[g * GROUP_W + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && is_start)
            begin
                seen_reg <= '0;
            end
            else if (pop && is_data)
            begin
                seen_reg <= seen_inc;
            end
            if (en)
            begin
                s1_valid_reg <= pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_data)
        begin
            win_reg[0] <= q_cmd.value;
            for (int i = 1; i < PATTERN_MAX - 1; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        if (sw_pend_reg)
        begin
            pat_reg[sw_pidx_reg] <= ram_rdata;
        end
        else if (load_hit)
        begin
            pat_reg[load_idx] <= q_cmd.value;
        end
        if (en)
        begin
            s1_kind_reg <= q_cmd.kind;
            s1_elig_reg <= CMP_W'(seen_inc) >= eff_x;
            s1_grp_reg  <= grp;
            s1_addr_reg <= q_cmd.addr - (ADDR_W'(eff) - ADDR_W'(1));
        end
    end

    // ----------------------------------------------------- match and output
    assign hit  = s1_valid_reg && (s1_kind_reg == KIND_DATA) && s1_elig_reg
                  && (&s1_grp_reg);
    assign emit = hit && (cnt_reg < maxm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= emit;
            if (s1_valid_reg && s1_kind_reg == KIND_START)
            begin
                cnt_reg <= '0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg + MAXM_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && emit)
        begin
            out_addr_reg <= s1_addr_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_addr_reg);

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (sweeping || sw_pend_reg) |-> !pop)
        else $error("item issued while pattern realignment in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(seen_reg) <= CMP_W'(PATTERN_MAX))
        else $error("bytes seen count beyond saturation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && s1_valid_reg && s1_kind_reg == KIND_START) |=> (cnt_reg == '0))
        else $error("start item did not clear the match count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && emit) |=> m_axis_tvalid)
        else $error("match result lost on its way to the output");
`endif

endmodule

>>> rtl/core/byte_pattern_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_search_core
// Streams memory bytes against a loaded byte pattern and reports the start
// address of every full match, up to max_matches per search.
// ----------------------------------------------------------------------------
// One item per clock is sustained while the engine is not paused: items enter
// a four-deep queue and the search engine issues one per cycle, comparing all
// pattern lanes against the window in parallel and settling the match in a
// second stage; a result passes through the second-stage registers and the
// output register on its way to m_axis. The engine pauses only while a result
// waits on m_axis, or during and after each pattern_length write, while the
// pattern is realigned from the pattern RAM one byte per cycle (items are
// still queued meanwhile). s_axis_tuser carries the operation: 0 load pattern
// byte, 1 start search, 2 data byte; code 3 is taken and discarded.
module byte_pattern_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot [6:0], byte_value [14:7], byte_address [46:15], zero pad above
    input  logic [bps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  logic [bps_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // match_address [31:0]
    output logic [bps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bps_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    bps_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .cmd           (front_cmd)
    );

    bps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (q_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    bps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_empty       (q_empty),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_pattern_search_core. Pattern loads, search
// starts and memory bytes go in on the input stream. A behavioural model of
// the sliding-window search predicts every match start address. Each result
// on the output stream is compared in order with those predictions or with a
// directed item's own expected address. A short table of directed items comes
// first. It is followed by randomised search phases with different pattern
// lengths, match caps, source idling and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

    import bps_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 7;
    // queue, two pipeline stages and a full pattern realign pass
    localparam int SETTLE_CYCLES = 160;
    localparam int TAIL_CYCLES   = 200;

    localparam logic [OP_W-1:0] OP_SPARE = OP_W'(3);

    typedef enum
    {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum
    {
        CHK_PREDICT,
        CHK_NONE,
        CHK_AT
    } check_t;

    typedef struct
    {
        row_kind_t              kind;
        logic [OP_W-1:0]        op;
        logic [SLOT_W-1:0]      slot;
        logic [BYTE_W-1:0]      val;
        logic [ADDR_W-1:0]      addr;
        check_t                 chk;
        logic [ADDR_W-1:0]      want;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } row_t;

    typedef struct
    {
        logic [PLEN_W-1:0]  len;
        logic [MAXM_W-1:0]  cap;
        int                 idle_pct;
        int                 stall_pct;
        int                 items;
        int                 hold;
        bit                 drain_mid;
    } phase_t;

    localparam int N_ROWS = 26;
    localparam int N_PHASES = 12;

    row_t directed_rows [N_ROWS] = '{
        '{ROW_ITEM, OP_LOAD,  7'd0,   8'hFF, 32'h0,        CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_LOAD,  7'd127, 8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_SPARE, 7'h7F,  8'hFF, 32'hFFFFFFFF, CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        // no start item yet: the search runs from reset
        '{ROW_ITEM, OP_DATA,  7'd0,   8'hFF, 32'h00000000, CHK_AT,      32'h00000000,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h00, 32'hFFFFFFFF, CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'hFF, 32'hFFFFFFFF, CHK_AT,      32'hFFFFFFFF,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_START, 7'd0,   8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        // length zero acts as one
        '{ROW_CFG,  OP_LOAD,  7'd0,   8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'hFF, 32'h00000005, CHK_AT,      32'h00000005,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_CFG,  OP_LOAD,  7'd0,   8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd3},
        '{ROW_CFG,  OP_LOAD,  7'd0,   8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_MAX_MATCHES,    16'd1},
        '{ROW_ITEM, OP_LOAD,  7'd0,   8'h11, 32'h0,        CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_LOAD,  7'd1,   8'h22, 32'h0,        CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_LOAD,  7'd2,   8'h33, 32'h0,        CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_START, 7'd0,   8'h00, 32'h0,        CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        // partial match at the head, then a full one wrapping below zero
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h11, 32'hFFFFFFFF, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h22, 32'h00000000, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h33, 32'h00000001, CHK_AT,      32'hFFFFFFFF,
          CFG_PATTERN_LENGTH, 16'd0},
        // cap of one already reached
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h11, 32'h00000002, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h22, 32'h00000003, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h33, 32'h00000004, CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_START, 7'd0,   8'h00, 32'h0,        CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h11, 32'h00000010, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h22, 32'h00000011, CHK_PREDICT, 32'h0,
          CFG_PATTERN_LENGTH, 16'd0},
        // cap of zero: full match, no result
        '{ROW_CFG,  OP_LOAD,  7'd0,   8'h00, 32'h0,        CHK_NONE,    32'h0,
          CFG_MAX_MATCHES,    16'd0},
        '{ROW_ITEM, OP_DATA,  7'd0,   8'h33, 32'h00000012, CHK_NONE,    32'h0,
          CFG_PATTERN_LENGTH, 16'd0}
    };

    phase_t phases [N_PHASES] = '{
        '{8'd1,   16'd65535, 0,  0,  110, 400, 1'b0},
        '{8'd2,   16'd20,    63, 0,  100, 0,   1'b0},
        '{8'd3,   16'd5,     0,  63, 100, 0,   1'b1},
        '{8'd4,   16'd65535, 20, 20, 100, 0,   1'b0},
        '{8'd128, 16'd65535, 0,  0,  140, 0,   1'b0},
        '{8'd5,   16'd1,     63, 0,  90,  0,   1'b0},
        '{8'd0,   16'd3,     0,  63, 90,  0,   1'b0},
        '{8'd255, 16'd2,     20, 20, 140, 0,   1'b0},
        '{8'd2,   16'd0,     0,  0,  60,  0,   1'b0},
        '{8'd8,   16'd65535, 63, 0,  100, 0,   1'b1},
        '{8'd3,   16'd20,    0,  63, 100, 0,   1'b0},
        '{8'd1,   16'd7,     20, 20, 90,  0,   1'b0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]         s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // search model state
    logic [BYTE_W-1:0]  pattern_mem [PATTERN_MAX];
    logic [BYTE_W-1:0]  window_mem [PATTERN_MAX] = '{default: '0};
    int                 bytes_in = 0;
    int                 hits = 0;
    logic [PLEN_W-1:0]  cur_len = PLEN_RESET;
    logic [MAXM_W-1:0]  cur_max = MAXM_RESET;

    logic [ADDR_W-1:0]  pending_matches [$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_req = 0;

    byte_pattern_search_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int used_length(input logic [PLEN_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(v);
    endfunction

    // advances the model by one item; returns 1 with the match start address
    function automatic bit search_step(input logic [OP_W-1:0] op,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [BYTE_W-1:0] val,
                                       input logic [ADDR_W-1:0] addr,
                                       output logic [ADDR_W-1:0] start_at);
        int n;
        int i;
        bit same;
        start_at = '0;
        if (op == OP_LOAD)
        begin
            pattern_mem[slot] = val;
            return 1'b0;
        end
        if (op == OP_START)
        begin
            for (i = 0; i < PATTERN_MAX; i++)
                window_mem[i] = '0;
            bytes_in = 0;
            hits = 0;
            return 1'b0;
        end
        if (op != OP_DATA)
            return 1'b0;
        for (i = PATTERN_MAX - 1; i > 0; i--)
            window_mem[i] = window_mem[i-1];
        window_mem[0] = val;
        if (bytes_in < PATTERN_MAX)
            bytes_in++;
        n = used_length(cur_len);
        if (bytes_in < n)
            return 1'b0;
        same = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (window_mem[n-1-i] != pattern_mem[i])
                same = 1'b0;
        end
        if (!same || hits >= cur_max)
            return 1'b0;
        hits++;
        start_at = addr - ADDR_W'(n - 1);
        return 1'b1;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [BYTE_W-1:0] val, input logic [ADDR_W-1:0] addr,
                             input check_t chk, input logic [ADDR_W-1:0] want);
        logic [ADDR_W-1:0] start_at;
        bit hit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({addr, val, slot});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit = search_step(op, slot, val, addr, start_at);
        if (chk == CHK_PREDICT && hit)
            pending_matches = {pending_matches, start_at};
        else if (chk == CHK_AT)
            pending_matches = {pending_matches, want};
    endtask

    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PATTERN_LENGTH)
            cur_len = val[PLEN_W-1:0];
        else if (idx == CFG_MAX_MATCHES)
            cur_max = val[MAXM_W-1:0];
    endtask

    // pattern load, length and cap writes, then a search stream rich in full copies of the pattern
    task automatic run_phase(input phase_t ph);
        logic [BYTE_W-1:0] alpha [4];
        logic [BYTE_W-1:0] pat [PATTERN_MAX];
        logic [BYTE_W-1:0] b;
        logic [SLOT_W-1:0] s;
        logic [ADDR_W-1:0] addr;
        int n;
        int k;
        int sent;
        int pick;
        bit paused;
        n = used_length(ph.len);
        for (k = 0; k < 4; k++)
            alpha[k] = BYTE_W'($urandom_range(255));
        for (k = 0; k < PATTERN_MAX; k++)
            pat[k] = alpha[2'($urandom_range(3))];
        send_idle_pct  = ph.idle_pct;
        recv_stall_pct = ph.stall_pct;
        for (k = 0; k < n; k++)
            send_item(OP_LOAD, SLOT_W'(k), pat[k], $urandom, CHK_PREDICT, '0);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(ph.len));
        write_reg(CFG_MAX_MATCHES, ph.cap);
        hold_req = ph.hold;
        addr = $urandom;
        send_item(OP_START, SLOT_W'($urandom), BYTE_W'($urandom), $urandom,
                  CHK_PREDICT, '0);
        sent = 0;
        paused = 1'b0;
        while (sent < ph.items)
        begin
            if (ph.drain_mid && !paused && sent >= ph.items / 2)
            begin
                await_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                for (k = 0; k < n; k++)
                begin
                    send_item(OP_DATA, SLOT_W'($urandom), pat[k], addr, CHK_PREDICT, '0);
                    addr++;
                    sent++;
                end
            end
            else if (pick < 90)
            begin
                b = $urandom_range(1) ? alpha[2'($urandom_range(3))] : BYTE_W'($urandom);
                send_item(OP_DATA, SLOT_W'($urandom), b, addr, CHK_PREDICT, '0);
                addr++;
                sent++;
            end
            else if (pick < 94)
            begin
                // address jump, sometimes just short of the wrap
                addr = $urandom_range(1) ? $urandom : 32'hFFFFFFFF - $urandom_range(150);
            end
            else if (pick < 97)
            begin
                send_item(OP_START, SLOT_W'($urandom), BYTE_W'($urandom), $urandom,
                          CHK_PREDICT, '0);
                sent++;
            end
            else if (pick < 99)
            begin
                s = SLOT_W'($urandom);
                b = alpha[2'($urandom_range(3))];
                pat[s] = b;
                send_item(OP_LOAD, s, b, $urandom, CHK_PREDICT, '0);
                sent++;
            end
            else
            begin
                send_item(OP_SPARE, SLOT_W'($urandom), BYTE_W'($urandom), $urandom,
                          CHK_PREDICT, '0);
                sent++;
            end
        end
    endtask

    // sink side: random stalls, plus long hold-offs on request
    initial
    begin
        int stretch;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stretch = hold_req;
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else if (m_axis_tdata[ADDR_W-1:0] !== pending_matches[0])
            begin
                $display("%0t: match_address mismatch, expected %h, got %h", $time,
                         pending_matches[0], m_axis_tdata[ADDR_W-1:0]);
                mismatches++;
                void'(pending_matches.pop_front());
            end
            else
            begin
                void'(pending_matches.pop_front());
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int r;
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (r = 0; r < N_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            else
                send_item(directed_rows[r].op, directed_rows[r].slot, directed_rows[r].val,
                          directed_rows[r].addr, directed_rows[r].chk,
                          directed_rows[r].want);
        end
        for (p = 0; p < N_PHASES; p++)
            run_phase(phases[p]);
        await_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
